// ----- rtl/sis_pkg.sv -----
// package for the stable insertion sorter
// types and constants shared by the sorter cells, output register and top level
`timescale 1ns / 1ps

package sis_pkg;

  // fixed field widths
  localparam int NodeW = 16;
  localparam int PosW  = 9;
  localparam int ArrW  = 10;

  // defaults for the top-level parameters
  localparam int DefCapacity = 512;
  localparam int DefKeyBits  = 20;

  // operation carried in s_axis_tuser
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_READ   = 1'b1
  } op_e;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rd;
  } cell_ctrl_t;

  // flags that travel with a read-out result
  typedef struct packed {
    logic dropped;
    logic was_empty;
    logic is_last;
  } out_flags_t;

endpackage

// ----- rtl/sis_cell.sv -----
// one cell of the sorting row: holds one record and trades it with its neighbors
// depends on sis_pkg
`timescale 1ns / 1ps

module sis_cell #(
  parameter int KEY_BITS = sis_pkg::DefKeyBits
) (
  input  logic                     clk_i,
  input  sis_pkg::cell_ctrl_t      ctrl_i,
  input  logic                     occ_i,      // this cell holds a record
  input  logic                     tail_i,     // first free cell
  input  logic                     gt_prev_i,  // lower neighbor key is greater than new key
  input  logic [KEY_BITS-1:0]      new_key_i,
  input  logic [sis_pkg::NodeW-1:0] new_node_i,
  input  logic [sis_pkg::PosW-1:0] new_pos_i,
  input  logic [KEY_BITS-1:0]      prev_key_i,
  input  logic [sis_pkg::NodeW-1:0] prev_node_i,
  input  logic [sis_pkg::PosW-1:0] prev_pos_i,
  input  logic [KEY_BITS-1:0]      next_key_i,
  input  logic [sis_pkg::NodeW-1:0] next_node_i,
  input  logic [sis_pkg::PosW-1:0] next_pos_i,
  output logic                     gt_o,
  output logic [KEY_BITS-1:0]      key_o,
  output logic [sis_pkg::NodeW-1:0] node_o,
  output logic [sis_pkg::PosW-1:0] pos_o
);

  logic [KEY_BITS-1:0]       key_q, key_d;
  logic [sis_pkg::NodeW-1:0] node_q, node_d;
  logic [sis_pkg::PosW-1:0]  pos_q, pos_d;

  // strictly greater keys move up, so equal keys keep arrival order
  assign gt_o = occ_i && (key_q > new_key_i);

  // next contents: shift up on insert, take the new record at the insertion point,
  // shift down on read-out
  always_comb begin
    key_d  = key_q;
    node_d = node_q;
    pos_d  = pos_q;
    if (ctrl_i.ins) begin
      if (gt_prev_i) begin
        key_d  = prev_key_i;
        node_d = prev_node_i;
        pos_d  = prev_pos_i;
      end else if (gt_o || tail_i) begin
        key_d  = new_key_i;
        node_d = new_node_i;
        pos_d  = new_pos_i;
      end
    end else if (ctrl_i.rd) begin
      key_d  = next_key_i;
      node_d = next_node_i;
      pos_d  = next_pos_i;
    end
  end

  // record payload, no reset
  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    node_q <= node_d;
    pos_q  <= pos_d;
  end

  assign key_o  = key_q;
  assign node_o = node_q;
  assign pos_o  = pos_q;

endmodule

// ----- rtl/sis_out_reg.sv -----
// output register for read-out results, holds a result until the master side takes it
// depends on sis_pkg
`timescale 1ns / 1ps

module sis_out_reg #(
  parameter int KEY_BITS = sis_pkg::DefKeyBits
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  logic                      take_i,
  input  logic [KEY_BITS-1:0]       key_i,
  input  logic [sis_pkg::NodeW-1:0] node_i,
  input  logic [sis_pkg::PosW-1:0]  pos_i,
  input  sis_pkg::out_flags_t       flags_i,
  output logic                      valid_o,
  output logic [KEY_BITS-1:0]       key_o,
  output logic [sis_pkg::NodeW-1:0] node_o,
  output logic [sis_pkg::PosW-1:0]  pos_o,
  output sis_pkg::out_flags_t       flags_o
);

  logic                      valid_q, valid_d;
  logic [KEY_BITS-1:0]       key_q;
  logic [sis_pkg::NodeW-1:0] node_q;
  logic [sis_pkg::PosW-1:0]  pos_q;
  sis_pkg::out_flags_t       flags_q;

  // valid holds until the transfer completes
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      key_q   <= key_i;
      node_q  <= node_i;
      pos_q   <= pos_i;
      flags_q <= flags_i;
    end
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign node_o  = node_q;
  assign pos_o   = pos_q;
  assign flags_o = flags_q;

endmodule

// ----- rtl/stable_insertion_sorter_top.sv -----
// top level of the stable insertion sorter: row of sorting cells, counters, output register
// depends on sis_pkg, sis_cell and sis_out_reg
`timescale 1ns / 1ps

// Stable ascending sorter built as a row of CAPACITY cells. Every cell compares its key
// with the incoming key at once and the whole row shifts in the same cycle, so one
// transfer can be accepted every cycle while s_axis_tready is high. A read-out
// result appears on the master side in the cycle after its transfer and waits in the
// output register; s_axis_tready is low only while that register holds a result the
// master side has not yet taken. Inserts produce no result. Equal keys leave in arrival
// order. An insert into a full row is dropped and reported on the next read-out; a
// read-out of an empty row returns was_empty with all other fields zero. No clearing pass
// is needed after reset: occupancy comes from the entry count alone.
module stable_insertion_sorter_top #(
  parameter int CAPACITY = sis_pkg::DefCapacity,
  parameter int KEY_BITS = sis_pkg::DefKeyBits,
  localparam int InW  = ((KEY_BITS + sis_pkg::NodeW + 7) / 8) * 8,
  localparam int OutW = ((KEY_BITS + sis_pkg::NodeW + sis_pkg::PosW + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InW-1:0]      s_axis_tdata,   // open_time, node_id
  input  logic                s_axis_tuser,   // operation
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutW-1:0]     m_axis_tdata,   // sorted_key, sorted_node, arrival_position
  output logic                m_axis_tlast,   // is_last
  output logic [1:0]          m_axis_tuser    // was_empty, insert_dropped
);

  localparam int CntW = $clog2(CAPACITY + 1);

  localparam logic [CntW-1:0] CntFull = CntW'(CAPACITY);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  // input fields
  logic [KEY_BITS-1:0]       in_key;
  logic [sis_pkg::NodeW-1:0] in_node;
  sis_pkg::op_e              in_op;

  assign in_key  = s_axis_tdata[KEY_BITS-1:0];
  assign in_node = s_axis_tdata[KEY_BITS +: sis_pkg::NodeW];
  assign in_op   = sis_pkg::op_e'(s_axis_tuser);

  // control state
  logic [CntW-1:0]          count_q, count_d;
  logic [sis_pkg::ArrW-1:0] arr_q, arr_d;
  logic                     drop_q, drop_d;

  logic                acc, is_rd, full, empty, out_valid;
  sis_pkg::cell_ctrl_t ctrl;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign is_rd         = (in_op == sis_pkg::OP_READ);
  assign full          = (count_q == CntFull);
  assign empty         = (count_q == '0);
  assign ctrl.ins      = acc && !is_rd && !full;
  assign ctrl.rd       = acc && is_rd && !empty;

  // counters and drop flag
  always_comb begin
    count_d = count_q;
    arr_d   = arr_q;
    drop_d  = drop_q;
    if (ctrl.ins) begin
      count_d = count_q + CntOne;
      arr_d   = arr_q + sis_pkg::ArrW'(1);
    end
    if (ctrl.rd) begin
      count_d = count_q - CntOne;
      if (count_q == CntOne) begin
        arr_d = '0;
      end
    end
    if (acc && !is_rd && full) begin
      drop_d = 1'b1;
    end
    if (acc && is_rd) begin
      drop_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      arr_q   <= '0;
      drop_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      arr_q   <= arr_d;
      drop_q  <= drop_d;
    end
  end

  // row of cells
  logic [KEY_BITS-1:0]       cell_key  [CAPACITY];
  logic [sis_pkg::NodeW-1:0] cell_node [CAPACITY];
  logic [sis_pkg::PosW-1:0]  cell_pos  [CAPACITY];
  logic [CAPACITY-1:0]       cell_gt;
  logic [sis_pkg::PosW-1:0]  new_pos;

  assign new_pos = arr_q[sis_pkg::PosW-1:0];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CntW-1:0] Idx = CntW'(i);

    logic                      gt_prev;
    logic [KEY_BITS-1:0]       prev_key, next_key;
    logic [sis_pkg::NodeW-1:0] prev_node, next_node;
    logic [sis_pkg::PosW-1:0]  prev_pos, next_pos;

    // neighbor links, ends tied off
    if (i == 0) begin : g_first
      assign gt_prev   = 1'b0;
      assign prev_key  = in_key;
      assign prev_node = in_node;
      assign prev_pos  = new_pos;
    end else begin : g_inner_lo
      assign gt_prev   = cell_gt[i-1];
      assign prev_key  = cell_key[i-1];
      assign prev_node = cell_node[i-1];
      assign prev_pos  = cell_pos[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_key  = '0;
      assign next_node = '0;
      assign next_pos  = '0;
    end else begin : g_inner_hi
      assign next_key  = cell_key[i+1];
      assign next_node = cell_node[i+1];
      assign next_pos  = cell_pos[i+1];
    end

    sis_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occ_i       (Idx < count_q),
      .tail_i      (Idx == count_q),
      .gt_prev_i   (gt_prev),
      .new_key_i   (in_key),
      .new_node_i  (in_node),
      .new_pos_i   (new_pos),
      .prev_key_i  (prev_key),
      .prev_node_i (prev_node),
      .prev_pos_i  (prev_pos),
      .next_key_i  (next_key),
      .next_node_i (next_node),
      .next_pos_i  (next_pos),
      .gt_o        (cell_gt[i]),
      .key_o       (cell_key[i]),
      .node_o      (cell_node[i]),
      .pos_o       (cell_pos[i])
    );
  end

  // read-out result, taken from the head cell
  logic [KEY_BITS-1:0]       res_key, out_key;
  logic [sis_pkg::NodeW-1:0] res_node, out_node;
  logic [sis_pkg::PosW-1:0]  res_pos, out_pos;
  sis_pkg::out_flags_t       res_flags, out_flags;

  always_comb begin
    res_key             = empty ? '0 : cell_key[0];
    res_node            = empty ? '0 : cell_node[0];
    res_pos             = empty ? '0 : cell_pos[0];
    res_flags.is_last   = !empty && (count_q == CntOne);
    res_flags.was_empty = empty;
    res_flags.dropped   = !empty && drop_q;
  end

  sis_out_reg #(
    .KEY_BITS (KEY_BITS)
  ) u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (acc && is_rd),
    .take_i  (m_axis_tready),
    .key_i   (res_key),
    .node_i  (res_node),
    .pos_i   (res_pos),
    .flags_i (res_flags),
    .valid_o (out_valid),
    .key_o   (out_key),
    .node_o  (out_node),
    .pos_o   (out_pos),
    .flags_o (out_flags)
  );

  // master-side packing
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OutW'({out_pos, out_node, out_key});
  assign m_axis_tlast  = out_flags.is_last;
  assign m_axis_tuser  = {out_flags.dropped, out_flags.was_empty};

  // assertions

  // entry count stays within the row
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("entry count beyond capacity");

  // an empty read-out carries no record
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0 && !m_axis_tlast
                                            && !m_axis_tuser[1]))
    else $error("empty read-out with nonzero fields");

  // reading the last record empties the row and restarts arrival numbering
  a_empty_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.rd && count_q == CntOne) |=> (count_q == '0 && arr_q == '0))
    else $error("row not empty after last read-out");

  // an insert into a full row is recorded as dropped
  a_drop_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && !is_rd && full) |=> (drop_q && count_q == CntFull))
    else $error("full-row insert not flagged");

endmodule
